// ===== hdl/nine_tap_box_blur_top_defines.svh =====
// ----------------------------------------------------------------------------
// nine_tap_box_blur_top_defines
// Assertion macros shared by the blur block. Each one samples on clk and
// is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef NINE_TAP_BOX_BLUR_TOP_DEFINES_SVH
`define NINE_TAP_BOX_BLUR_TOP_DEFINES_SVH

// condition must hold at every edge
`define NTBB_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define NTBB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/ntbb_pkg.sv =====
// ----------------------------------------------------------------------------
// ntbb_pkg
// Codes, command/status types and the reciprocal table for the blur block.
// ----------------------------------------------------------------------------
`default_nettype none
package ntbb_pkg;

  localparam int DEF_MAX_WIDTH  = 128;
  localparam int DEF_MAX_HEIGHT = 128;

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_RUN  = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  localparam logic [1:0] RPL_LOAD = 2'd0;
  localparam logic [1:0] RPL_PASS = 2'd1;
  localparam logic [1:0] RPL_READ = 2'd2;

  localparam logic [7:0] CFG_IMG_W  = 8'd0;
  localparam logic [7:0] CFG_IMG_H  = 8'd1;
  localparam logic [7:0] CFG_RADIUS = 8'd2;
  localparam logic [7:0] CFG_PASSES = 8'd3;

  localparam logic [3:0] FIRST_TAP  = 4'd0;
  localparam logic [3:0] CENTER_TAP = 4'd4;
  localparam logic [3:0] LAST_TAP   = 4'd8;

  typedef struct packed {
    logic       ld_wr;
    logic       rd_issue;
    logic       pass_init;
    logic       tap_issue;
    logic [3:0] tap_k;
    logic       acc_clr;
    logic       mul;
    logic       wr_scr;
    logic       pix_clr;
    logic       pix_inc;
    logic       copy_rd;
    logic       out_load;
    logic [1:0] out_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic       last_pix;
    logic [7:0] npass;
  } dp_stat_t;

  // floor(65536/n)+1: (s*recip)>>16 gives floor(s/n) for s below 2296
  function automatic logic [16:0] tap_recip(input logic [3:0] n);
    logic [16:0] r;
    unique case (n)
      4'd1:    r = 17'd65537;
      4'd2:    r = 17'd32769;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16385;
      4'd5:    r = 17'd13108;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8193;
      4'd9:    r = 17'd7282;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/ntbb_ifs.sv =====
// ----------------------------------------------------------------------------
// ntbb_ifs
// Request, reply and configuration channels of the blur block.
// ----------------------------------------------------------------------------
`default_nettype none
interface ntbb_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [13:0] pixel_index;
  logic [7:0]  in_red;
  logic [7:0]  in_green;
  logic [7:0]  in_blue;
  logic [7:0]  in_alpha;
  modport source(output valid, req_type, pixel_index, in_red, in_green, in_blue, in_alpha,
                 input ready);
  modport sink(input valid, req_type, pixel_index, in_red, in_green, in_blue, in_alpha,
               output ready);
endinterface

interface ntbb_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] reply_kind;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;
  modport source(output valid, reply_kind, out_red, out_green, out_blue, out_alpha,
                 input ready);
  modport sink(input valid, reply_kind, out_red, out_green, out_blue, out_alpha,
               output ready);
endinterface

interface ntbb_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/ntbb_dpath.sv =====
// ----------------------------------------------------------------------------
// ntbb_dpath
// Image store, pass scratch, tap addressing, accumulators, reciprocal
// divide, copy-back path, config registers and reply register.
// ----------------------------------------------------------------------------
`default_nettype none
module ntbb_dpath
  import ntbb_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire dp_cmd_t     cmd,
  output dp_stat_t         stat,
  input  wire logic [13:0] pixel_index,
  input  wire logic [7:0]  in_red,
  input  wire logic [7:0]  in_green,
  input  wire logic [7:0]  in_blue,
  input  wire logic [7:0]  in_alpha,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  output logic [1:0]       reply_kind,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic [7:0]       out_alpha
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WCAP  = (MAX_WIDTH < 255) ? MAX_WIDTH : 255;
  localparam int HCAP  = (MAX_HEIGHT < 255) ? MAX_HEIGHT : 255;

  logic [31:0] store   [DEPTH];
  logic [31:0] scratch [DEPTH];

  logic [7:0]  w_r, h_r, np_r;
  logic [6:0]  rad_r;
  logic [7:0]  eff_w, eff_h;
  logic [15:0] total;
  logic        idx_ok;

  logic [15:0] p_r;
  logic [14:0] ry_r;
  logic signed [17:0] hoff, voff, q;
  logic        tap_ok;
  logic [AW-1:0] st_raddr;
  logic [31:0] st_q_r, scr_q_r, ctr_r, wd_r;
  logic        rd_ok_r, tv_r, cp_vld_r;
  logic [3:0]  tk_r, cnt_r;
  logic [AW-1:0] cp_addr_r;
  logic [11:0] sr_r, sg_r, sb_r;
  logic [16:0] recip;
  logic [28:0] pr, pg, pb;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r   <= 8'd128;
      h_r   <= 8'd128;
      rad_r <= 7'd1;
      np_r  <= 8'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMG_W:  w_r   <= cfg_data;
        CFG_IMG_H:  h_r   <= cfg_data;
        CFG_RADIUS: rad_r <= cfg_data[6:0];
        CFG_PASSES: np_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (w_r == 8'd0)          eff_w = 8'd1;
    else if (int'(w_r) > WCAP) eff_w = 8'(WCAP);
    else                       eff_w = w_r;
    if (h_r == 8'd0)          eff_h = 8'd1;
    else if (int'(h_r) > HCAP) eff_h = 8'(HCAP);
    else                       eff_h = h_r;
  end

  assign total  = {8'd0, eff_w} * {8'd0, eff_h};
  assign idx_ok = {2'b00, pixel_index} < total;

  // tap offsets: column from k mod 3, row from k div 3
  always_comb begin
    unique case (cmd.tap_k)
      4'd0, 4'd3, 4'd6: hoff = -$signed({11'd0, rad_r});
      4'd2, 4'd5, 4'd8: hoff = $signed({11'd0, rad_r});
      default:          hoff = 18'sd0;
    endcase
    unique case (cmd.tap_k)
      4'd0, 4'd1, 4'd2: voff = -$signed({3'd0, ry_r});
      4'd6, 4'd7, 4'd8: voff = $signed({3'd0, ry_r});
      default:          voff = 18'sd0;
    endcase
  end

  assign q        = $signed({2'b00, p_r}) + hoff + voff;
  assign tap_ok   = !q[17] && (q[16:0] < {1'b0, total});
  assign st_raddr = cmd.rd_issue ? AW'(pixel_index) : AW'(q[16:0]);

  // image store: load or copy-back write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.ld_wr && idx_ok) begin
      store[AW'(pixel_index)] <= {in_alpha, in_blue, in_green, in_red};
    end else if (cp_vld_r) begin
      store[cp_addr_r] <= scr_q_r;
    end
    st_q_r <= store[st_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_scr) begin
      scratch[AW'(p_r)] <= wd_r;
    end
    scr_q_r   <= scratch[AW'(p_r)];
    cp_addr_r <= AW'(p_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tv_r     <= 1'b0;
      cp_vld_r <= 1'b0;
      p_r      <= 16'd0;
    end else begin
      tv_r     <= cmd.tap_issue && tap_ok;
      cp_vld_r <= cmd.copy_rd;
      if (cmd.pass_init || cmd.pix_clr) p_r <= 16'd0;
      else if (cmd.pix_inc)             p_r <= p_r + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    tk_r <= cmd.tap_k;
    if (cmd.pass_init) ry_r <= {8'd0, rad_r} * {7'd0, eff_w};
    if (cmd.rd_issue)  rd_ok_r <= idx_ok;
    if (cmd.acc_clr) begin
      sr_r  <= 12'd0;
      sg_r  <= 12'd0;
      sb_r  <= 12'd0;
      cnt_r <= 4'd0;
    end else if (tv_r) begin
      sr_r  <= sr_r + {4'd0, st_q_r[7:0]};
      sg_r  <= sg_r + {4'd0, st_q_r[15:8]};
      sb_r  <= sb_r + {4'd0, st_q_r[23:16]};
      cnt_r <= cnt_r + 4'd1;
    end
    if (tv_r && tk_r == CENTER_TAP) ctr_r <= st_q_r;
  end

  assign recip = tap_recip(cnt_r);
  assign pr = {17'd0, sr_r} * {12'd0, recip};
  assign pg = {17'd0, sg_r} * {12'd0, recip};
  assign pb = {17'd0, sb_r} * {12'd0, recip};

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      // all-zero sums: copy the pixel through
      if ((sr_r | sg_r | sb_r) != 12'd0) wd_r <= {ctr_r[31:24], pb[23:16], pg[23:16], pr[23:16]};
      else                               wd_r <= ctr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      reply_kind <= cmd.out_kind;
      if (cmd.out_kind == RPL_READ && rd_ok_r) begin
        out_red   <= st_q_r[7:0];
        out_green <= st_q_r[15:8];
        out_blue  <= st_q_r[23:16];
        out_alpha <= st_q_r[31:24];
      end else begin
        out_red   <= 8'd0;
        out_green <= 8'd0;
        out_blue  <= 8'd0;
        out_alpha <= 8'd0;
      end
    end
  end

  assign stat.last_pix = (p_r == total - 16'd1);
  assign stat.npass    = np_r;

endmodule
`default_nettype wire

// ===== hdl/ntbb_ctrl.sv =====
// ----------------------------------------------------------------------------
// ntbb_ctrl
// Request sequencer: load/read handshake, tap walk per pixel, copy-back
// sweep per pass and the reply valid flag.
// ----------------------------------------------------------------------------
`default_nettype none
`include "nine_tap_box_blur_top_defines.svh"
module ntbb_ctrl
  import ntbb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [1:0] req_type,
  output logic            in_ready,
  input  wire logic       out_ready,
  output logic            out_valid,
  input  wire dp_stat_t   stat,
  output dp_cmd_t         cmd
);

  typedef enum logic [3:0] {
    IDLE, RD_WAIT, P_TAP, P_DRAIN, P_MUL, P_WR, C_RUN, C_LAST, DONE
  } state_t;

  state_t     state_r;
  logic       out_valid_r;
  logic [3:0] k_r;
  logic [7:0] pc_r;
  logic       in_fire;
  logic       more_pass;

  assign in_ready  = (state_r == IDLE) && (!out_valid_r || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign more_pass = ({1'b0, pc_r} + 9'd1) != {1'b0, stat.npass};

  always_comb begin
    cmd       = '0;
    cmd.tap_k = k_r;
    unique case (state_r)
      IDLE: begin
        if (in_fire) begin
          if (req_type == REQ_LOAD) begin
            cmd.ld_wr    = 1'b1;
            cmd.out_load = 1'b1;
            cmd.out_kind = RPL_LOAD;
          end else if (req_type == REQ_READ) begin
            cmd.rd_issue = 1'b1;
          end else if (req_type == REQ_RUN) begin
            cmd.pass_init = (stat.npass != 8'd0);
          end
        end
      end
      RD_WAIT: begin
        cmd.out_load = 1'b1;
        cmd.out_kind = RPL_READ;
      end
      P_TAP: begin
        cmd.tap_issue = 1'b1;
        cmd.acc_clr   = (k_r == FIRST_TAP);
      end
      P_DRAIN: ;
      P_MUL:   cmd.mul = 1'b1;
      P_WR: begin
        cmd.wr_scr  = 1'b1;
        cmd.pix_clr = stat.last_pix;
        cmd.pix_inc = !stat.last_pix;
      end
      C_RUN: begin
        cmd.copy_rd = 1'b1;
        cmd.pix_inc = !stat.last_pix;
      end
      C_LAST: cmd.pass_init = more_pass;
      DONE: begin
        cmd.out_load = 1'b1;
        cmd.out_kind = RPL_PASS;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      out_valid_r <= 1'b0;
      k_r         <= FIRST_TAP;
      pc_r        <= 8'd0;
    end else begin
      if (cmd.out_load)   out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        IDLE: begin
          if (in_fire) begin
            if (req_type == REQ_READ) begin
              state_r <= RD_WAIT;
            end else if (req_type == REQ_RUN) begin
              pc_r <= 8'd0;
              k_r  <= FIRST_TAP;
              state_r <= (stat.npass == 8'd0) ? DONE : P_TAP;
            end
          end
        end
        RD_WAIT: state_r <= IDLE;
        P_TAP: begin
          if (k_r == LAST_TAP) begin
            state_r <= P_DRAIN;
          end else begin
            k_r <= k_r + 4'd1;
          end
        end
        P_DRAIN: state_r <= P_MUL;
        P_MUL:   state_r <= P_WR;
        P_WR: begin
          k_r     <= FIRST_TAP;
          state_r <= stat.last_pix ? C_RUN : P_TAP;
        end
        C_RUN: begin
          if (stat.last_pix) state_r <= C_LAST;
        end
        C_LAST: begin
          // advance to next pass or finish
          if (more_pass) begin
            pc_r    <= pc_r + 8'd1;
            k_r     <= FIRST_TAP;
            state_r <= P_TAP;
          end else begin
            state_r <= DONE;
          end
        end
        DONE:    state_r <= IDLE;
        default: state_r <= IDLE;
      endcase
    end
  end

  `NTBB_ASSERT_NXT(a_run_starts, in_fire && req_type == REQ_RUN && stat.npass != 8'd0, state_r == P_TAP && k_r == FIRST_TAP, "run request did not start tap walk")
  `NTBB_ASSERT_NXT(a_done_reply, state_r == DONE, out_valid_r, "finished passes gave no reply")
  `NTBB_ASSERT(a_no_overrun, !(out_valid_r && !out_ready && in_fire), "request taken while reply stalled")
  `NTBB_ASSERT_NXT(a_read_reply, state_r == RD_WAIT, out_valid_r && state_r == IDLE, "read gave no reply")

endmodule
`default_nettype wire

// ===== hdl/nine_tap_box_blur_top.sv =====
// Requests: a load reply is valid in the cycle after the load is taken; a read goes via
// RD_WAIT; req_type 3 is taken with no reply. Run: each pass does, per pixel, nine store
// reads on one port, drain, divide, write, then a copy-back sweep; DONE then replies.
// Throughput: one load per cycle while replies are taken; one request at a time.
// Reset: rst_n synchronous, active low; registers back to 128, 128, 1, 1.
// Stores are not cleared: pixels hold garbage until loaded.
// ----------------------------------------------------------------------------
// nine_tap_box_blur_top
// Dilated 3x3 box blur over an RGBA image store with load/run/read requests.
// ----------------------------------------------------------------------------
`default_nettype none
module nine_tap_box_blur_top
  import ntbb_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input wire logic  clk,
  input wire logic  rst_n,
  ntbb_req_if.sink   in_ch,
  ntbb_rsp_if.source out_ch,
  ntbb_cfg_if.sink   cfg_ch
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     cfg_we;

  assign cfg_ch.ready = 1'b1;
  assign cfg_we       = cfg_ch.valid && cfg_ch.ready;

  ntbb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .req_type  (in_ch.req_type),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  ntbb_dpath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .pixel_index (in_ch.pixel_index),
    .in_red      (in_ch.in_red),
    .in_green    (in_ch.in_green),
    .in_blue     (in_ch.in_blue),
    .in_alpha    (in_ch.in_alpha),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_ch.index),
    .cfg_data    (cfg_ch.data),
    .reply_kind  (out_ch.reply_kind),
    .out_red     (out_ch.out_red),
    .out_green   (out_ch.out_green),
    .out_blue    (out_ch.out_blue),
    .out_alpha   (out_ch.out_alpha)
  );

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the dilated 3x3 box blur. Loads small images,
// runs blur passes and reads pixels back under several size, radius and
// pass settings, with random gaps on the request side and random
// back-pressure on the reply side. Every reply is compared with a
// behavioral blur kept in a scoreboard.
// ----------------------------------------------------------------------------
`default_nettype none
module tb
  import ntbb_pkg::*;
();

  localparam int          STORE_DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
  localparam logic [1:0]  REQ_NONE    = 2'd3;
  localparam logic [7:0]  CFG_UNUSED  = 8'd9;

  typedef enum int {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [13:0] idx;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
  } pix_req_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pix_reply_t;

  class blur_scoreboard;
    logic [31:0] image[STORE_DEPTH];
    logic [31:0] scratch[STORE_DEPTH];
    bit          loaded[STORE_DEPTH];
    int          width_reg, height_reg, radius_reg, passes_reg;
    pix_reply_t  replies_due[$];
    int          mismatches, loads, runs, reads, passes_done, checked;

    function void set_register(logic [7:0] idx, logic [7:0] data);
      case (idx)
        CFG_IMG_W:  width_reg  = int'(data);
        CFG_IMG_H:  height_reg = int'(data);
        CFG_RADIUS: radius_reg = int'(data[6:0]);
        CFG_PASSES: passes_reg = int'(data);
        default: ;
      endcase
    endfunction

    function int eff_w();
      return width_reg < 1 ? 1 : (width_reg > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : width_reg);
    endfunction

    function int eff_h();
      return height_reg < 1 ? 1 : (height_reg > DEF_MAX_HEIGHT ? DEF_MAX_HEIGHT : height_reg);
    endfunction

    function bit image_complete();
      for (int i = 0; i < eff_w() * eff_h(); i++)
        if (!loaded[14'(i)]) return 0;
      return 1;
    endfunction

    function void blur_once();
      int w, total, q, taps;
      int sr, sg, sb;
      logic [31:0] v, centre;
      w = eff_w();
      total = w * eff_h();
      for (int p = 0; p < total; p++) begin
        sr = 0; sg = 0; sb = 0; taps = 0;
        centre = image[14'(p)];
        for (int dy = -1; dy <= 1; dy++) begin
          for (int dx = -1; dx <= 1; dx++) begin
            q = p + dx * radius_reg + dy * radius_reg * w;
            if (q >= 0 && q < total) begin
              v = image[14'(q)];
              sr += int'(v[7:0]); sg += int'(v[15:8]); sb += int'(v[23:16]);
              taps++;
            end
          end
        end
        if (taps != 0 && (sr | sg | sb) != 0)
          scratch[14'(p)] = {centre[31:24], 8'(sb / taps), 8'(sg / taps), 8'(sr / taps)};
        else
          scratch[14'(p)] = centre;
      end
      for (int p = 0; p < total; p++) image[14'(p)] = scratch[14'(p)];
    endfunction

    function void note_request(pix_req_t rq);
      pix_reply_t rp;
      int total;
      total = eff_w() * eff_h();
      rp = '0;
      case (rq.kind)
        REQ_LOAD: begin
          loads++;
          if (rq.idx < total) begin
            image[rq.idx] = {rq.alpha, rq.blue, rq.green, rq.red};
            loaded[rq.idx] = 1;
          end
          rp.kind = RPL_LOAD;
        end
        REQ_RUN: begin
          runs++;
          for (int i = 0; i < passes_reg; i++) blur_once();
          passes_done += passes_reg;
          rp.kind = RPL_PASS;
        end
        REQ_READ: begin
          reads++;
          rp.kind = RPL_READ;
          if (rq.idx < total)
            {rp.alpha, rp.blue, rp.green, rp.red} = image[rq.idx];
        end
        default: return;
      endcase
      replies_due = {replies_due, rp};
    endfunction

    function void check_reply(pix_reply_t got);
      pix_reply_t exp_rp;
      checked++;
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected reply kind %0d", got.kind);
        return;
      end
      exp_rp = replies_due.pop_front();
      if (got.kind !== exp_rp.kind || got.red !== exp_rp.red || got.green !== exp_rp.green ||
          got.blue !== exp_rp.blue || got.alpha !== exp_rp.alpha) begin
        mismatches++;
        if (mismatches <= 10)
          $display("reply mismatch: exp kind %0d rgba %h %h %h %h, got kind %0d rgba %h %h %h %h",
                   exp_rp.kind, exp_rp.red, exp_rp.green, exp_rp.blue, exp_rp.alpha,
                   got.kind, got.red, got.green, got.blue, got.alpha);
      end
    endfunction
  endclass

  logic clk, rst_n;
  ntbb_req_if req_ch();
  ntbb_rsp_if rsp_ch();
  ntbb_cfg_if cfg_ch();

  nine_tap_box_blur_top u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (req_ch),
    .out_ch(rsp_ch),
    .cfg_ch(cfg_ch)
  );

  blur_scoreboard sb = new();
  idle_mode_t     idle_mode = IDLE_NONE;
  int             hold_req = 0;
  int             loaded_idx[$];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("timeout");
    $display("[nine_tap_box_blur_top] ERROR");
    $finish;
  end

  // reply side: random back-pressure plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (idle_mode == IDLE_RX || idle_mode == IDLE_BOTH)
        rsp_ch.ready <= ($urandom_range(99) >= 76);
      else
        rsp_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && rsp_ch.valid && rsp_ch.ready)
      sb.check_reply({rsp_ch.reply_kind, rsp_ch.out_red, rsp_ch.out_green,
                      rsp_ch.out_blue, rsp_ch.out_alpha});
  end

  task automatic send(pix_req_t rq);
    if ((idle_mode == IDLE_TX || idle_mode == IDLE_BOTH) && $urandom_range(99) < 76) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 76);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= rq.kind;
    req_ch.pixel_index <= rq.idx;
    req_ch.in_red      <= rq.red;
    req_ch.in_green    <= rq.green;
    req_ch.in_blue     <= rq.blue;
    req_ch.in_alpha    <= rq.alpha;
    do @(posedge clk); while (!req_ch.ready);
    if (rq.kind == REQ_LOAD && rq.idx < sb.eff_w() * sb.eff_h() && !sb.loaded[rq.idx])
      loaded_idx = {loaded_idx, int'(rq.idx)};
    sb.note_request(rq);
  endtask

  task automatic send_load(int idx, logic [31:0] rgba);
    send({REQ_LOAD, 14'(idx), rgba[7:0], rgba[15:8], rgba[23:16], rgba[31:24]});
  endtask

  task automatic send_op(logic [1:0] kind, int idx);
    send({kind, 14'(idx), 32'($urandom)});
  endtask

  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (sb.replies_due.size() != 0) @(posedge clk);
    // wait out a trailing no-reply request
    repeat (5) @(posedge clk);
  endtask

  task automatic cfg_write(logic [7:0] idx, logic [7:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    sb.set_register(idx, data);
    @(posedge clk);
  endtask

  task automatic run_phase(int w, int h, int rad, int passes, idle_mode_t mode,
                           int n_rand, int hold);
    int total, pick, idx;
    bit found;
    wait_idle();
    cfg_write(CFG_IMG_W, 8'(w));
    cfg_write(CFG_IMG_H, 8'(h));
    cfg_write(CFG_RADIUS, 8'(rad));
    cfg_write(CFG_PASSES, 8'(passes));
    idle_mode = mode;
    hold_req = hold;
    total = sb.eff_w() * sb.eff_h();
    if (total <= 300)
      for (int i = 0; i < total; i++) send_load(i, $urandom);
    for (int n = 0; n < n_rand; n++) begin
      pick = $urandom_range(99);
      if (pick < 10 && (passes == 0 || sb.image_complete())) begin
        send_op(REQ_RUN, $urandom);
      end else if (pick < 15) begin
        send_op(REQ_NONE, $urandom);
      end else if (pick < 55) begin
        found = 0;
        if (total < STORE_DEPTH && $urandom_range(99) < 15) begin
          idx = $urandom_range(STORE_DEPTH - 1, total);
          found = 1;
        end else begin
          for (int t = 0; t < 30 && !found && loaded_idx.size() != 0; t++) begin
            idx = loaded_idx[$urandom_range(loaded_idx.size() - 1)];
            found = (idx < total);
          end
        end
        if (found) send_op(REQ_READ, idx);
        else send_load($urandom_range(total - 1), $urandom);
      end else if (total < STORE_DEPTH && $urandom_range(99) < 10) begin
        send_load($urandom_range(STORE_DEPTH - 1, total), $urandom);
      end else begin
        send_load($urandom_range(total - 1), $urandom);
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    req_ch.valid <= 1'b0;
    req_ch.req_type <= REQ_LOAD;
    req_ch.pixel_index <= '0;
    {req_ch.in_red, req_ch.in_green, req_ch.in_blue, req_ch.in_alpha} <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_IMG_W;
    cfg_ch.data  <= '0;
    sb.set_register(CFG_IMG_W, 8'd128);
    sb.set_register(CFG_IMG_H, 8'd128);
    sb.set_register(CFG_RADIUS, 8'd1);
    sb.set_register(CFG_PASSES, 8'd1);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: 2x2 image, all-zero copy, extremes, off-image access, unused type
    cfg_write(CFG_UNUSED, 8'hFF);
    cfg_write(CFG_IMG_W, 8'd2);
    cfg_write(CFG_IMG_H, 8'd2);
    for (int i = 0; i < 4; i++) send_load(i, 32'h0);
    send_op(REQ_RUN, 0);
    send_op(REQ_READ, 0);
    send_load(3, 32'hFFFF_FFFF);
    send_load(16383, 32'hFFFF_FFFF);
    send_op(REQ_READ, 16383);
    send_op(REQ_NONE, 16383);
    send_op(REQ_RUN, 0);
    for (int i = 0; i < 4; i++) send_op(REQ_READ, i);
    send_load(0, 32'h00FF_00FF);
    send_op(REQ_RUN, 0);
    send_op(REQ_READ, 0);
    send_op(REQ_READ, 3);

    run_phase(4, 4, 1, 1, IDLE_NONE, 100, 0);
    run_phase(128, 128, 1, 0, IDLE_NONE, 130, 0);
    run_phase(8, 5, 2, 3, IDLE_TX, 110, 0);
    run_phase(1, 1, 0, 255, IDLE_RX, 60, 0);
    run_phase(255, 0, 127, 2, IDLE_RX, 90, 0);
    run_phase(0, 200, 5, 1, IDLE_BOTH, 90, 0);
    run_phase(7, 9, 1, 4, IDLE_NONE, 120, 400);
    run_phase(10, 6, 3, 1, IDLE_BOTH, 110, 0);
    run_phase(12, 3, 0, 2, IDLE_TX, 100, 0);

    wait_idle();
    repeat (20) @(posedge clk);
    $display("covered %0d loads, %0d reads, %0d run requests (%0d blur passes)",
             sb.loads, sb.reads, sb.runs, sb.passes_done);
    $display("%0d replies checked, %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.replies_due.size() == 0)
      $display("[nine_tap_box_blur_top] OK");
    else
      $display("[nine_tap_box_blur_top] ERROR");
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+hdl
hdl/ntbb_pkg.sv
hdl/ntbb_ifs.sv
hdl/ntbb_dpath.sv
hdl/ntbb_ctrl.sv
hdl/nine_tap_box_blur_top.sv
tb/sv/tb.sv
